// ===== hdl/mts_pkg.sv =====
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and constants of the feedback-queue task scheduler.
// ----------------------------------------------------------------------------
package mts_pkg;

   localparam int SLOT_COUNT  = 16;
   localparam int SLOT_W      = 4;
   localparam int CNT_W       = 5;
   localparam int LEVEL_W     = 2;
   localparam int BUDGET_W    = 8;

   localparam logic [LEVEL_W-1:0] LEVEL_LAST = 2'd3;
   localparam logic [CNT_W-1:0]   SLOTS_CNT  = 5'd16;

   localparam logic [1:0] ST_READY   = 2'd0;
   localparam logic [1:0] ST_RUNNING = 2'd1;

   localparam logic ACT_TICK  = 1'b0;
   localparam logic ACT_WRITE = 1'b1;

   localparam logic [0:0] CSR_BOOST_INTERVAL = 1'd0;
   localparam logic [0:0] CSR_SLICE_UNIT     = 1'd1;

   typedef struct packed {
      logic                used;
      logic [1:0]          status;
      logic [LEVEL_W-1:0]  level;
      logic [BUDGET_W-1:0] budget;
   } entry_type;

   typedef struct packed {
      logic                wr_en;
      logic [SLOT_W-1:0]   wr_addr;
      entry_type           wr_data;
      logic [SLOT_W-1:0]   rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic                action;
      logic [SLOT_W-1:0]   slot;
      logic                in_use;
      logic [1:0]          status;
      logic [LEVEL_W-1:0]  level;
      logic [BUDGET_W-1:0] slice;
      logic [CNT_W-1:0]    count;
   } req_type;

   typedef struct packed {
      logic                level_found;
      logic [LEVEL_W-1:0]  chosen_level;
      logic                boosted;
      logic                switched;
      logic                running_valid;
      logic [SLOT_W-1:0]   running_slot;
   } rsp_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_BOOST,
      S_SCAN,
      S_START,
      S_PICK,
      S_CUR_RD,
      S_CUR_WB,
      S_PICK_RD,
      S_PICK_WB,
      S_DONE
   } seq_state_type;

endpackage

// ===== hdl/mts_slot_mem.sv =====
// ----------------------------------------------------------------------------
// mts_slot_mem
// Slot table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mts_slot_mem (
   input  logic                 clock,
   input  mts_pkg::mem_req_type mem_req,
   output mts_pkg::entry_type   rd_data
);
   import mts_pkg::*;

   entry_type mem_ff [SLOT_COUNT];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_data_ff <= mem_ff[mem_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/mts_sequencer.sv =====
// ----------------------------------------------------------------------------
// mts_sequencer
// Walks the slot table per tick: boost sweep, level scan, round-robin pick,
// demotion of the running slot and update of the chosen slot.
// ----------------------------------------------------------------------------
module mts_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mts_pkg::req_type     req,
   input  logic [15:0]          boost_interval,
   input  logic [5:0]           slice_unit,
   input  logic                 out_free,
   output logic                 rsp_load,
   output mts_pkg::rsp_type     rsp,
   output mts_pkg::mem_req_type mem_req,
   input  mts_pkg::entry_type   rd_data
);
   import mts_pkg::*;

   seq_state_type       state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [SLOT_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [SLOT_W-1:0]   ptr_ff, ptr_in;
   logic [CNT_W-1:0]    start_ff, start_in;
   logic [SLOT_W-1:0]   cur_ff, cur_in;
   logic                cur_vld_ff, cur_vld_in;
   logic [CNT_W-1:0]    n_ff, n_in;
   logic [15:0]         bcnt_ff, bcnt_in;
   logic                boosted_ff, boosted_in;
   logic                found_ff, found_in;
   logic [LEVEL_W-1:0]  level_ff, level_in;
   logic                have_ff, have_in;
   logic [SLOT_W-1:0]   pick_ff, pick_in;

   logic [15:0]         bc1, lim;
   logic                do_boost;
   logic                active;
   logic [SLOT_W-1:0]   ptr_next;
   logic [LEVEL_W-1:0]  nl;
   logic [2:0]          mult;
   logic [8:0]          demote_b;
   entry_type           wb;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         cnt_ff     <= '0;
         rd_vld_ff  <= 1'b0;
         cur_ff     <= '0;
         cur_vld_ff <= 1'b0;
         n_ff       <= '0;
         bcnt_ff    <= '0;
         boosted_ff <= 1'b0;
         found_ff   <= 1'b0;
         level_ff   <= '0;
         have_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         rd_vld_ff  <= rd_vld_in;
         cur_ff     <= cur_in;
         cur_vld_ff <= cur_vld_in;
         n_ff       <= n_in;
         bcnt_ff    <= bcnt_in;
         boosted_ff <= boosted_in;
         found_ff   <= found_in;
         level_ff   <= level_in;
         have_ff    <= have_in;
      end
      rd_idx_ff <= rd_idx_in;
      ptr_ff    <= ptr_in;
      start_ff  <= start_in;
      pick_ff   <= pick_in;
   end

   assign bc1      = bcnt_ff + 16'd1;
   assign lim      = (boost_interval == 16'd0) ? 16'd1 : boost_interval;
   assign do_boost = (bc1 >= lim) || (bc1 == 16'd0);
   assign active   = rd_data.used &&
                     ((rd_data.status == ST_READY) || (rd_data.status == ST_RUNNING));
   assign ptr_next = ({1'b0, ptr_ff} + 5'd1 == n_ff) ? '0 : ptr_ff + 1'b1;
   assign nl       = rd_data.level + 1'b1;
   assign mult     = {1'b0, nl} + 3'd1;
   assign demote_b = mult * slice_unit;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      rd_vld_in  = 1'b0;
      rd_idx_in  = rd_idx_ff;
      ptr_in     = ptr_ff;
      start_in   = start_ff;
      cur_in     = cur_ff;
      cur_vld_in = cur_vld_ff;
      n_in       = n_ff;
      bcnt_in    = bcnt_ff;
      boosted_in = boosted_ff;
      found_in   = found_ff;
      level_in   = level_ff;
      have_in    = have_ff;
      pick_in    = pick_ff;
      req_ready  = 1'b0;
      rsp_load   = 1'b0;
      mem_req    = '0;
      wb         = rd_data;

      unique case (state_ff)
         S_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = cnt_ff[SLOT_W-1:0];
            cnt_in          = cnt_ff + 1'b1;
            if (cnt_ff == SLOTS_CNT - 5'd1) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               boosted_in = 1'b0;
               found_in   = 1'b0;
               level_in   = '0;
               have_in    = 1'b0;
               cnt_in     = '0;
               if (req.action == ACT_WRITE) begin
                  mem_req.wr_en          = 1'b1;
                  mem_req.wr_addr        = req.slot;
                  mem_req.wr_data.used   = req.in_use;
                  mem_req.wr_data.status = req.status;
                  mem_req.wr_data.level  = req.level;
                  mem_req.wr_data.budget = req.slice;
                  n_in     = (req.count > SLOTS_CNT) ? SLOTS_CNT : req.count;
                  state_in = S_DONE;
               end else if (n_ff == '0) begin
                  state_in = S_DONE;
               end else begin
                  bcnt_in    = do_boost ? 16'd0 : bc1;
                  boosted_in = do_boost;
                  state_in   = do_boost ? S_BOOST : S_SCAN;
               end
            end
         end
         S_BOOST: begin
            mem_req.rd_addr = cnt_ff[SLOT_W-1:0];
            rd_idx_in       = cnt_ff[SLOT_W-1:0];
            if (cnt_ff != SLOTS_CNT) begin
               rd_vld_in = 1'b1;
               cnt_in    = cnt_ff + 1'b1;
            end
            if (rd_vld_ff && rd_data.used) begin
               wb.level        = '0;
               wb.budget       = {2'b00, slice_unit};
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = rd_idx_ff;
               mem_req.wr_data = wb;
            end
            if (cnt_ff == SLOTS_CNT && !rd_vld_ff) begin
               cnt_in   = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            mem_req.rd_addr = cnt_ff[SLOT_W-1:0];
            rd_idx_in       = cnt_ff[SLOT_W-1:0];
            if (cnt_ff != n_ff) begin
               rd_vld_in = 1'b1;
               cnt_in    = cnt_ff + 1'b1;
            end
            if (rd_vld_ff && active && (!found_ff || rd_data.level < level_ff)) begin
               found_in = 1'b1;
               level_in = rd_data.level;
            end
            if (cnt_ff == n_ff && !rd_vld_ff) begin
               cnt_in   = '0;
               start_in = cur_vld_ff ? {1'b0, cur_ff} + 5'd1 : '0;
               state_in = found_ff ? S_START : S_DONE;
            end
         end
         S_START: begin
            if (start_ff >= n_ff) begin
               start_in = start_ff - n_ff;
            end else begin
               ptr_in   = start_ff[SLOT_W-1:0];
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            mem_req.rd_addr = ptr_ff;
            rd_idx_in       = ptr_ff;
            if (cnt_ff != n_ff) begin
               rd_vld_in = 1'b1;
               cnt_in    = cnt_ff + 1'b1;
               ptr_in    = ptr_next;
            end
            if (rd_vld_ff && !have_ff && rd_data.used && rd_data.status == ST_READY &&
                rd_data.level == level_ff) begin
               have_in = 1'b1;
               pick_in = rd_idx_ff;
            end
            if (cnt_ff == n_ff && !rd_vld_ff) begin
               state_in = have_ff ? S_CUR_RD : S_DONE;
            end
         end
         S_CUR_RD: begin
            mem_req.rd_addr = cur_ff;
            state_in        = S_CUR_WB;
         end
         S_CUR_WB: begin
            if (cur_vld_ff && rd_data.status == ST_RUNNING) begin
               wb.status = ST_READY;
               if (rd_data.budget == '0 && rd_data.level != LEVEL_LAST) begin
                  wb.level  = nl;
                  wb.budget = demote_b[8] ? 8'hFF : demote_b[7:0];
               end
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = cur_ff;
               mem_req.wr_data = wb;
            end
            state_in = S_PICK_RD;
         end
         S_PICK_RD: begin
            mem_req.rd_addr = pick_ff;
            state_in        = S_PICK_WB;
         end
         S_PICK_WB: begin
            wb.status = ST_RUNNING;
            if (rd_data.budget != '0) begin
               wb.budget = rd_data.budget - 1'b1;
            end
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = pick_ff;
            mem_req.wr_data = wb;
            cur_in          = pick_ff;
            cur_vld_in      = 1'b1;
            state_in        = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp.running_slot  = cur_ff;
      rsp.running_valid = cur_vld_ff;
      rsp.switched      = have_ff;
      rsp.boosted       = boosted_ff;
      rsp.chosen_level  = level_ff;
      rsp.level_found   = found_ff;
   end

endmodule

// ===== hdl/mlfq_task_scheduler.sv =====
// A tick runs an optional boost sweep and a level scan, then if a level is found the
// start-slot wrap and round-robin pick, then if a slot is picked the running and
// chosen slot write-backs. A write or an empty tick goes straight to the done state.
// One request is in work at a time; the next is taken when the sequencer returns to
// idle on loading the response. Synchronous active-high reset clears control state,
// then a pass zeroes each of the 16 slots with the request side held not ready.
// ----------------------------------------------------------------------------
// mlfq_task_scheduler
// Four-level feedback-queue task picker over a sixteen-slot table.
// ----------------------------------------------------------------------------
module mlfq_task_scheduler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // slot, slot_in_use, slot_status, slot_level,
                                   // slot_slice, slot_count
   input  logic        req_tuser,  // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // running_slot, running_valid, switched, boosted,
                                   // chosen_level, level_found
   input  logic        csr_wr_en,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import mts_pkg::*;

   logic [15:0] boost_interval_ff;
   logic [5:0]  slice_unit_ff;
   logic        rsp_tvalid_ff;
   rsp_type     rsp_ff;
   rsp_type     rsp;
   logic        rsp_load;
   logic        out_free;
   req_type     req;
   mem_req_type mem_req;
   entry_type   rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         boost_interval_ff <= 16'd1000;
         slice_unit_ff     <= 6'd10;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BOOST_INTERVAL: boost_interval_ff <= csr_wdata;
            CSR_SLICE_UNIT:     slice_unit_ff     <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   assign out_free = !rsp_tvalid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_ff <= rsp;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {6'd0, rsp_ff};

   assign req.action = req_tuser;
   assign req.slot   = req_tdata[3:0];
   assign req.in_use = req_tdata[4];
   assign req.status = req_tdata[6:5];
   assign req.level  = req_tdata[8:7];
   assign req.slice  = req_tdata[16:9];
   assign req.count  = req_tdata[21:17];

   mts_sequencer u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .req            (req),
      .boost_interval (boost_interval_ff),
      .slice_unit     (slice_unit_ff),
      .out_free       (out_free),
      .rsp_load       (rsp_load),
      .rsp            (rsp),
      .mem_req        (mem_req),
      .rd_data        (rd_data)
   );

   mts_slot_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

// ===== bench/tb_mlfq_task_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mlfq_task_scheduler
// Self-checking bench for the feedback-queue task scheduler: a directed
// table of requests, then random slot writes and scheduling ticks under
// several boost and slice settings. Responses are checked with a typed
// row's value or an in-bench model. Both sides idle at random when not calm.
// ----------------------------------------------------------------------------
module tb_mlfq_task_scheduler;
   import mts_pkg::*;

   typedef struct {
      logic       action;
      logic [3:0] slot;
      logic       in_use;
      logic [1:0] status;
      logic [1:0] level;
      logic [7:0] slice;
      logic [4:0] count;
      bit         typed;
      rsp_type    rsp;
   } row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        csr_wr_en;
   logic [0:0]  csr_index;
   logic [15:0] csr_wdata;

   logic       used_q[16];
   logic [1:0] state_q[16];
   logic [1:0] level_q[16];
   logic [7:0] budget_q[16];
   logic [3:0] cur_slot;
   logic       cur_valid;
   logic [4:0] scan_n;
   logic [15:0] boost_cnt;
   logic [15:0] boost_ivl;
   logic [5:0]  slice_u;

   rsp_type pending_rsp[$];
   int      errors;
   bit      calm;
   row_type rows[$];

   mlfq_task_scheduler DUT (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic rsp_type schedule(row_type r);
      rsp_type o;
      int      n, lim, lv, start, idx, pick, nl, b;
      bit      found, have;
      o = '0;
      if (r.action == ACT_WRITE) begin
         used_q[r.slot] = r.in_use;
         state_q[r.slot] = r.status;
         level_q[r.slot] = r.level;
         budget_q[r.slot] = r.slice;
         scan_n = (r.count > SLOTS_CNT) ? SLOTS_CNT : r.count;
      end else if (scan_n != 0) begin
         n = scan_n;
         lim = (boost_ivl == 0) ? 1 : boost_ivl;
         boost_cnt = boost_cnt + 16'd1;
         if (boost_cnt >= lim || boost_cnt == 0) begin
            boost_cnt = '0;
            o.boosted = 1'b1;
            for (int i = 0; i < 16; i++)
               if (used_q[i]) begin
                  level_q[i] = '0;
                  budget_q[i] = {2'b00, slice_u};
               end
         end
         found = 0;
         lv = 0;
         for (int q = 0; q < 4 && !found; q++)
            for (int i = 0; i < n && !found; i++)
               if (used_q[i] && (state_q[i] == ST_READY || state_q[i] == ST_RUNNING)
                   && level_q[i] == q) begin
                  found = 1;
                  lv = q;
               end
         if (found) begin
            start = cur_valid ? (cur_slot + 1) % n : 0;
            have = 0;
            pick = 0;
            for (int i = 0; i < n && !have; i++) begin
               idx = (start + i) % n;
               if (used_q[idx] && state_q[idx] == ST_READY && level_q[idx] == lv) begin
                  pick = idx;
                  have = 1;
               end
            end
            if (have) begin
               if (cur_valid && state_q[cur_slot] == ST_RUNNING) begin
                  state_q[cur_slot] = ST_READY;
                  if (budget_q[cur_slot] == 0 && level_q[cur_slot] < LEVEL_LAST) begin
                     nl = level_q[cur_slot] + 1;
                     b = (nl + 1) * slice_u;
                     level_q[cur_slot] = 2'(nl);
                     budget_q[cur_slot] = (b > 255) ? 8'd255 : 8'(b);
                  end
               end
               cur_slot = 4'(pick);
               cur_valid = 1'b1;
               state_q[pick] = ST_RUNNING;
               if (budget_q[pick] > 0) budget_q[pick] = budget_q[pick] - 8'd1;
            end
            o.switched = have;
            o.chosen_level = 2'(lv);
            o.level_found = 1'b1;
         end
      end
      o.running_slot = cur_slot;
      o.running_valid = cur_valid;
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[9:0];
         if (pending_rsp.size() == 0) begin
            $display("%0t unexpected response %h", $time, got);
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            if (got != want) begin
               $display({"%0t mismatch: expected slot=%0d valid=%0d sw=%0d boost=%0d",
                         " lvl=%0d found=%0d, actual slot=%0d valid=%0d sw=%0d",
                         " boost=%0d lvl=%0d found=%0d"},
                        $time, want.running_slot, want.running_valid, want.switched,
                        want.boosted, want.chosen_level, want.level_found,
                        got.running_slot, got.running_valid, got.switched,
                        got.boosted, got.chosen_level, got.level_found);
               errors++;
            end
         end
      end
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready = calm || ($urandom_range(0, 99) >= 18);
      end
   end

   task automatic send(row_type r);
      rsp_type p;
      if (!calm && $urandom_range(0, 99) < 18) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = r.action;
      req_tdata = {2'b00, r.count, r.slice, r.level, r.status, r.in_use, r.slot};
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      p = schedule(r);
      pending_rsp.push_back(r.typed ? r.rsp : p);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic configure(logic [15:0] ivl, logic [5:0] su);
      wait (pending_rsp.size() == 0);
      repeat (5) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = CSR_BOOST_INTERVAL;
      csr_wdata = ivl;
      @(negedge clock);
      csr_index = CSR_SLICE_UNIT;
      csr_wdata = {10'd0, su};
      @(negedge clock);
      csr_wr_en = 1'b0;
      boost_ivl = ivl;
      slice_u = su;
   endtask

   function automatic row_type mk(logic a, logic [3:0] s, logic u, logic [1:0] st,
                                  logic [1:0] lv, logic [7:0] sl, logic [4:0] c);
      row_type r;
      r.action = a; r.slot = s; r.in_use = u; r.status = st;
      r.level = lv; r.slice = sl; r.count = c;
      r.typed = 0; r.rsp = '0;
      return r;
   endfunction

   initial begin
      row_type r;
      logic [15:0] ivls[5];
      logic [5:0]  sus[5];
      ivls = '{16'd1000, 16'd1, 16'd65535, 16'd3, 16'd7};
      sus  = '{6'd10, 6'd63, 6'd1, 6'd20, 6'd5};
      errors = 0;
      calm = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = ACT_TICK;
      csr_wr_en = 1'b0;
      csr_index = CSR_BOOST_INTERVAL;
      csr_wdata = '0;
      for (int i = 0; i < 16; i++) begin
         used_q[i] = 0; state_q[i] = '0; level_q[i] = '0; budget_q[i] = '0;
      end
      cur_slot = '0; cur_valid = 0; scan_n = '0; boost_cnt = '0;
      boost_ivl = 16'd1000; slice_u = 6'd10;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty tick, fill the table, ticks, then rewrite slot 3 and tick
      r = mk(ACT_TICK, 4'd15, 1, 2'd3, 2'd3, 8'hff, 5'd16);
      r.typed = 1;
      rows.push_back(r);
      for (int i = 0; i < 16; i++) begin
         r = mk(ACT_WRITE, 4'(i), (i % 5) != 4, 2'(i % 3), 2'(i % 4),
                (i == 0) ? 8'd0 : (i == 1) ? 8'd252 : 8'(i * 7),
                (i == 15) ? 5'd16 : 5'(i));
         r.typed = 1;
         rows.push_back(r);
      end
      for (int i = 0; i < 6; i++) rows.push_back(mk(ACT_TICK, 0, 0, 0, 0, 0, 0));
      rows.push_back(mk(ACT_WRITE, 4'd3, 1, ST_READY, 2'd0, 8'd0, 5'd4));
      rows.push_back(mk(ACT_TICK, 0, 0, 0, 0, 0, 0));

      configure(ivls[0], sus[0]);
      foreach (rows[i]) send(rows[i]);

      for (int ph = 0; ph < 5; ph++) begin
         if (ph > 0) configure(ivls[ph], sus[ph]);
         calm = (ph == 2);
         for (int k = 0; k < 140; k++) begin
            r.action = ($urandom_range(0, 99) < 30) ? ACT_WRITE : ACT_TICK;
            r.slot = 4'($urandom_range(0, 15));
            r.in_use = ($urandom_range(0, 9) != 0);
            r.status = 2'($urandom_range(0, 2));
            r.level = 2'($urandom_range(0, 3));
            r.slice = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3)) :
                      8'($urandom_range(0, 252));
            r.count = ($urandom_range(0, 19) == 0) ? 5'd0 :
                      ($urandom_range(0, 3) == 0) ? 5'd16 : 5'($urandom_range(1, 16));
            r.typed = 0;
            send(r);
         end
      end
      calm = 0;

      wait (pending_rsp.size() == 0);
      repeat (100) @(posedge clock);
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
